>>> hdl/olist_pkg.sv
`default_nettype none

package olist_pkg;

  // Request codes
  localparam logic [3:0] OP_INS_POS   = 4'd0;
  localparam logic [3:0] OP_INS_FRONT = 4'd1;
  localparam logic [3:0] OP_INS_REAR  = 4'd2;
  localparam logic [3:0] OP_DEL_POS   = 4'd3;
  localparam logic [3:0] OP_DEL_FIRST = 4'd4;
  localparam logic [3:0] OP_DEL_LAST  = 4'd5;
  localparam logic [3:0] OP_READ      = 4'd6;
  localparam logic [3:0] OP_READ_DEL  = 4'd7;
  localparam logic [3:0] OP_FIND      = 4'd8;
  localparam logic [3:0] OP_TEST_FST  = 4'd9;
  localparam logic [3:0] OP_TEST_LST  = 4'd10;
  localparam logic [3:0] OP_CLEAR     = 4'd11;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic ins;   // open a slot at the target and load the key there
    logic del;   // close the slot at the target
    logic find;  // scan hits on key equality instead of on the target index
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/ordered_list_engine_core.sv
`default_nettype none

// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+---------------------------------
// request  | in_op, in_position, in_value            | word taken when start & !busy
// result   | out_status, out_data_out,               | word shown for one cycle with
//          | out_found_position, out_match, out_count| out_valid; cannot be held off
//
// Inserts, clear and unused codes go from accept straight to the update cycle;
// the result word is registered and shown in the cycle after it. Every other
// request first runs a scan token down the row of DEPTH cells, one cell per
// cycle, before its update. busy rises after accept and stays high through update.
// rst_n (synchronous) empties the list; entry contents are not cleared.
// The result side never stalls the block.

module ordered_list_engine_core #(
  parameter int DEPTH = 64
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  wire logic [3:0]  in_op,
  input  wire logic [6:0]  in_position,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [31:0]      out_data_out,
  output logic [5:0]       out_found_position,
  output logic             out_match,
  output logic [6:0]       out_count
);
  import olist_pkg::*;

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] scan_cnt_r, scan_cnt_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    op_r;
  logic [6:0]    pos_r;
  logic [31:0]   key_r;
  logic [IW-1:0] tgt_r, tgt_nxt;
  logic          accept;
  logic          needs_scan;

  logic          out_valid_r;
  logic [2:0]    out_status_r, status_nxt;
  logic [31:0]   out_data_r, data_nxt;
  logic [5:0]    out_fpos_r, fpos_nxt;
  logic          out_match_r, match_nxt;
  logic [6:0]    out_count_r;

  cell_ctrl_t    ctrl;

  logic [31:0]   cell_data  [DEPTH];
  logic          scan_found [DEPTH];
  logic [31:0]   scan_data  [DEPTH];
  logic [IW-1:0] scan_pos   [DEPTH];

  logic [CMPW-1:0] pos_w, cnt_w;
  logic            cnt_zero, cnt_full;
  logic [IW-1:0]   cnt_last;

  assign accept   = start & ~busy;
  assign busy     = (state_r != S_IDLE);
  assign cnt_last = IW'(cnt_r - 1'b1);

  // Pick the cell index the request works on
  always_comb begin
    tgt_nxt    = IW'(in_position);
    needs_scan = 1'b1;
    unique case (in_op)
      OP_INS_POS:   needs_scan = 1'b0;
      OP_INS_FRONT: begin
        tgt_nxt    = '0;
        needs_scan = 1'b0;
      end
      OP_INS_REAR:  begin
        tgt_nxt    = IW'(cnt_r);
        needs_scan = 1'b0;
      end
      OP_DEL_FIRST, OP_TEST_FST: tgt_nxt = '0;
      OP_DEL_LAST, OP_TEST_LST:  tgt_nxt = cnt_last;
      OP_DEL_POS, OP_READ, OP_READ_DEL, OP_FIND: ;
      default: needs_scan = 1'b0;
    endcase
  end

  // Latch the request word; it holds through scan and update
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      pos_r <= in_position;
      key_r <= in_value;
      tgt_r <= tgt_nxt;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt    = needs_scan ? S_SCAN : S_FIN;
          scan_cnt_nxt = '0;
        end
      end
      S_SCAN: begin
        // leave the scan once the last cell's token is valid
        if (scan_cnt_r == IW'(DEPTH - 1)) begin
          state_nxt = S_FIN;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign pos_w    = CMPW'(pos_r);
  assign cnt_w    = CMPW'(cnt_r);
  assign cnt_zero = (cnt_r == '0);
  assign cnt_full = (cnt_r == CW'(DEPTH));

  // Update cycle: resolve status, drive the shift, form the result word
  always_comb begin
    status_nxt = ST_OK;
    data_nxt   = '0;
    fpos_nxt   = '0;
    match_nxt  = 1'b0;
    cnt_nxt    = cnt_r;
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.find  = (op_r == OP_FIND);
    if (state_r == S_FIN) begin
      unique case (op_r)
        OP_INS_POS, OP_INS_FRONT, OP_INS_REAR: begin
          if ((op_r == OP_INS_POS) && (pos_w > cnt_w)) begin
            status_nxt = ST_RANGE;
          end else if (cnt_full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        OP_DEL_POS, OP_READ, OP_READ_DEL: begin
          if (pos_w >= cnt_w) begin
            status_nxt = ST_RANGE;
          end else begin
            data_nxt = scan_data[DEPTH-1];
            if (op_r != OP_READ) begin
              ctrl.del = 1'b1;
              cnt_nxt  = cnt_r - 1'b1;
            end
          end
        end
        OP_DEL_FIRST, OP_DEL_LAST: begin
          if (cnt_zero) begin
            status_nxt = ST_EMPTY;
          end else begin
            data_nxt = scan_data[DEPTH-1];
            ctrl.del = 1'b1;
            cnt_nxt  = cnt_r - 1'b1;
          end
        end
        OP_FIND: begin
          if (cnt_zero) begin
            status_nxt = ST_EMPTY;
          end else if (scan_found[DEPTH-1]) begin
            fpos_nxt = 6'(scan_pos[DEPTH-1]);
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end
        OP_TEST_FST, OP_TEST_LST: begin
          if (cnt_zero) begin
            status_nxt = ST_EMPTY;
          end else begin
            match_nxt = (scan_data[DEPTH-1] == key_r);
          end
        end
        OP_CLEAR: cnt_nxt = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_cnt_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == S_FIN);
    end
  end

  // Result word registers; valid only with the strobe
  always_ff @(posedge clk) begin
    if (state_r == S_FIN) begin
      out_status_r <= status_nxt;
      out_data_r   <= data_nxt;
      out_fpos_r   <= fpos_nxt;
      out_match_r  <= match_nxt;
      out_count_r  <= 7'(cnt_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_data_out       = out_data_r;
  assign out_found_position = out_fpos_r;
  assign out_match          = out_match_r;
  assign out_count          = out_count_r;

  // Row of cells; each entry talks only to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0]   left_d, right_d;
    logic          sf_in;
    logic [31:0]   sd_in;
    logic [IW-1:0] sp_in;

    if (i == 0) begin : g_head
      assign left_d = key_r;
      assign sf_in  = 1'b0;
      assign sd_in  = '0;
      assign sp_in  = '0;
    end else begin : g_body
      assign left_d = cell_data[i-1];
      assign sf_in  = scan_found[i-1];
      assign sd_in  = scan_data[i-1];
      assign sp_in  = scan_pos[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = key_r;
    end else begin : g_mid
      assign right_d = cell_data[i+1];
    end

    olist_cell #(
      .IW  (IW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .tgt          (tgt_r),
      .cnt          (cnt_r),
      .key          (key_r),
      .left_data    (left_d),
      .right_data   (right_d),
      .data         (cell_data[i]),
      .scan_found_i (sf_in),
      .scan_data_i  (sd_in),
      .scan_pos_i   (sp_in),
      .scan_found_o (scan_found[i]),
      .scan_data_o  (scan_data[i]),
      .scan_pos_o   (scan_pos[i])
    );
  end

endmodule

`default_nettype wire

>>> hdl/olist_cell.sv
`default_nettype none

module olist_cell #(
  parameter int IW  = 6,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  wire                     clk,
  input  wire olist_pkg::cell_ctrl_t ctrl,
  input  wire logic [IW-1:0]      tgt,
  input  wire logic [CW-1:0]      cnt,
  input  wire logic [31:0]        key,
  input  wire logic [31:0]        left_data,
  input  wire logic [31:0]        right_data,
  output logic      [31:0]        data,
  input  wire logic               scan_found_i,
  input  wire logic [31:0]        scan_data_i,
  input  wire logic [IW-1:0]      scan_pos_i,
  output logic                    scan_found_o,
  output logic      [31:0]        scan_data_o,
  output logic      [IW-1:0]      scan_pos_o
);
  import olist_pkg::*;

  localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
  localparam logic [CW-1:0] MY_IDX_C = CW'(IDX);

  logic [31:0]   data_r;
  logic          scan_found_r;
  logic [31:0]   scan_data_r;
  logic [IW-1:0] scan_pos_r;
  logic          hit;

  // Entry: shift right on insert, left on delete, otherwise hold
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_IDX > tgt) begin
        data_r <= left_data;
      end else if (MY_IDX == tgt) begin
        data_r <= key;
      end
    end else if (ctrl.del) begin
      if (MY_IDX >= tgt) begin
        data_r <= right_data;
      end
    end
  end

  assign hit = ctrl.find ? ((MY_IDX_C < cnt) && (data_r == key)) : (MY_IDX == tgt);

  // Scan token: keep the first hit seen upstream, else take this cell's
  always_ff @(posedge clk) begin
    scan_found_r <= scan_found_i | hit;
    scan_data_r  <= scan_found_i ? scan_data_i : data_r;
    scan_pos_r   <= scan_found_i ? scan_pos_i  : MY_IDX;
  end

  assign data         = data_r;
  assign scan_found_o = scan_found_r;
  assign scan_data_o  = scan_data_r;
  assign scan_pos_o   = scan_pos_r;

endmodule

`default_nettype wire

>>> verif/tb_ordered_list_engine_core.sv
`timescale 1ns / 1ps

module tb_ordered_list_engine_core;
  import olist_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int DRAIN_CYCLES = LIST_DEPTH + 16;
  localparam int NUM_DIRECTED = 25;

  // Codes the block leaves unused; it must answer them with ok and no change
  localparam logic [3:0] OP_SPARE_FIRST = 4'd12;
  localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

  // One result word as the block reports it
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data;
    logic [5:0]  fpos;
    logic        match;
    logic [6:0]  count;
  } olist_word_t;

  // One row of the directed table; exp only counts where typed is set
  typedef struct packed {
    logic [3:0]  op;
    logic [6:0]  pos;
    logic [31:0] val;
    logic        typed;
    olist_word_t exp;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  in_op;
  logic [6:0]  in_position;
  logic [31:0] in_value;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_data_out;
  logic [5:0]  out_found_position;
  logic        out_match;
  logic [6:0]  out_count;

  // Shadow copy of the list, updated when each request word is taken
  logic [31:0] list_vals [LIST_DEPTH];
  int unsigned list_len;

  olist_word_t pending_words[$];
  olist_word_t oldest_word;
  stim_row_t   directed_rows [NUM_DIRECTED];
  int          mismatch_count;
  int          sender_idle_pct;

  ordered_list_engine_core #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_data_out      (out_data_out),
    .out_found_position(out_found_position),
    .out_match         (out_match),
    .out_count         (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Remove the entry at pos and close the gap behind it
  function automatic logic [31:0] take_entry(input int unsigned pos);
    logic [31:0] taken;
    taken = list_vals[pos];
    for (int unsigned i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
    list_len--;
    return taken;
  endfunction

  // Apply one request to the shadow list and return the word it must produce
  function automatic olist_word_t list_response(input logic [3:0] op, input logic [6:0] pos_in,
                                                input logic [31:0] val);
    olist_word_t w;
    int unsigned pos;
    bit          hit;
    w = '0;
    pos = pos_in;
    hit = 1'b0;
    case (op)
      OP_INS_POS, OP_INS_FRONT, OP_INS_REAR: begin
        if (op == OP_INS_FRONT) pos = 0;
        else if (op == OP_INS_REAR) pos = list_len;
        // range is judged before fullness
        if (pos > list_len) w.status = ST_RANGE;
        else if (list_len >= LIST_DEPTH) w.status = ST_FULL;
        else begin
          for (int unsigned i = list_len; i > pos; i--) list_vals[i] = list_vals[i - 1];
          list_vals[pos] = val;
          list_len++;
        end
      end
      OP_DEL_POS, OP_READ, OP_READ_DEL: begin
        // an empty list falls into the range error here as well
        if (pos >= list_len) w.status = ST_RANGE;
        else if (op == OP_READ) w.data = list_vals[pos];
        else w.data = take_entry(pos);
      end
      OP_DEL_FIRST, OP_DEL_LAST: begin
        if (list_len == 0) w.status = ST_EMPTY;
        else w.data = take_entry(op == OP_DEL_FIRST ? 0 : list_len - 1);
      end
      OP_FIND: begin
        if (list_len == 0) w.status = ST_EMPTY;
        else begin
          for (int unsigned i = 0; i < list_len; i++) begin
            if (!hit && list_vals[i] == val) begin
              hit = 1'b1;
              w.fpos = i[5:0];
            end
          end
          w.status = hit ? ST_OK : ST_NOTFOUND;
        end
      end
      OP_TEST_FST, OP_TEST_LST: begin
        if (list_len == 0) w.status = ST_EMPTY;
        else w.match = (list_vals[op == OP_TEST_FST ? 0 : list_len - 1] == val);
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    w.count = list_len[6:0];
    return w;
  endfunction

  function automatic stim_row_t mk_row(input logic [3:0] op, input logic [6:0] pos,
                                       input logic [31:0] val, input logic typed,
                                       input logic [2:0] status, input logic [31:0] data,
                                       input logic [6:0] count);
    stim_row_t r;
    r.op = op;
    r.pos = pos;
    r.val = val;
    r.typed = typed;
    r.exp.status = status;
    r.exp.data = data;
    r.exp.fpos = '0;
    r.exp.match = 1'b0;
    r.exp.count = count;
    return r;
  endfunction

  // Present one request word from a falling edge, hold it until the block takes
  // it, log the expected result, then idle the request side at random.
  task automatic send_word(input logic [3:0] op, input logic [6:0] pos, input logic [31:0] val,
                           input logic typed, input olist_word_t typed_word);
    olist_word_t predicted;
    int          gap;
    start = 1'b1;
    in_op = op;
    in_position = pos;
    in_value = val;
    // busy read right after the edge still holds its pre-edge value
    do @(posedge clk); while (busy);
    predicted = list_response(op, pos, val);
    pending_words.push_back(typed ? typed_word : predicted);
    @(negedge clk);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      // mostly short gaps, sometimes long enough to land after busy drops
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, LIST_DEPTH + 6) : $urandom_range(1, 3);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Pick a value: often one already stored or from a tiny pool so finds and
  // tests hit, otherwise fully random.
  function automatic logic [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30 && list_len != 0) return list_vals[$urandom_range(0, list_len - 1)];
    if (sel < 50) return 32'($signed($urandom_range(0, 4)) - 2);
    return $urandom;
  endfunction

  // Draw one random request, mostly well formed against the current list
  task automatic send_random_word(inout int counted);
    logic [3:0]  op;
    logic [6:0]  pos;
    int unsigned sel;
    bit          noisy;
    sel = $urandom_range(0, 99);
    noisy = ($urandom_range(0, 99) < 15);
    if (sel < 32) op = 4'($urandom_range(OP_INS_POS, OP_INS_REAR));
    else if (sel < 60) op = 4'($urandom_range(OP_DEL_POS, OP_READ_DEL));
    else if (sel < 93) op = 4'($urandom_range(OP_FIND, OP_TEST_LST));
    else if (sel < 96) op = OP_CLEAR;
    else op = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    if (noisy) pos = 7'($urandom_range(0, 127));
    else if (op == OP_INS_POS) pos = 7'($urandom_range(0, list_len));
    else if (list_len != 0) pos = 7'($urandom_range(0, list_len - 1));
    else pos = 7'($urandom_range(0, 127));
    send_word(op, pos, pick_value(), 1'b0, '0);
    // ignored codes do not count toward the item budget
    if (op < OP_SPARE_FIRST) counted++;
  endtask

  // Fill the list to capacity, then push against the limit
  task automatic fill_list();
    while (list_len < LIST_DEPTH)
      send_word(4'($urandom_range(OP_INS_POS, OP_INS_REAR)), 7'($urandom_range(0, list_len)),
                pick_value(), 1'b0, '0);
    send_word(OP_INS_REAR, 7'($urandom_range(0, 127)), $urandom, 1'b0, '0);
    send_word(OP_INS_POS, 7'(LIST_DEPTH), $urandom, 1'b0, '0);
    // beyond count: range wins over full
    send_word(OP_INS_POS, 7'($urandom_range(LIST_DEPTH + 1, 127)), $urandom, 1'b0, '0);
    send_word(OP_INS_FRONT, '0, $urandom, 1'b0, '0);
  endtask

  // Check every result word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $error("out_valid with no expected word: status %0d count %0d", out_status, out_count);
        mismatch_count++;
      end else begin
        oldest_word = pending_words.pop_front();
        if (out_status !== oldest_word.status) begin
          $error("out_status: expected %0d, got %0d", oldest_word.status, out_status);
          mismatch_count++;
        end
        if (out_data_out !== oldest_word.data) begin
          $error("out_data_out: expected %0d, got %0d", $signed(oldest_word.data),
                 $signed(out_data_out));
          mismatch_count++;
        end
        if (out_found_position !== oldest_word.fpos) begin
          $error("out_found_position: expected %0d, got %0d", oldest_word.fpos,
                 out_found_position);
          mismatch_count++;
        end
        if (out_match !== oldest_word.match) begin
          $error("out_match: expected %0d, got %0d", oldest_word.match, out_match);
          mismatch_count++;
        end
        if (out_count !== oldest_word.count) begin
          $error("out_count: expected %0d, got %0d", oldest_word.count, out_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int counted;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = '0;
    in_position = '0;
    in_value = '0;
    list_len = 0;
    mismatch_count = 0;
    sender_idle_pct = 6;
    for (int i = 0; i < LIST_DEPTH; i++) list_vals[i] = '0;

    // Walk an empty list through its error cases, then build and take apart
    // a short list holding both value extremes.
    directed_rows = '{
      mk_row(OP_DEL_FIRST,   7'd0,   32'd0,          1'b1, ST_EMPTY, 32'd0,          7'd0),
      mk_row(OP_DEL_LAST,    7'd0,   32'd0,          1'b1, ST_EMPTY, 32'd0,          7'd0),
      mk_row(OP_READ,        7'd0,   32'd0,          1'b1, ST_RANGE, 32'd0,          7'd0),
      mk_row(OP_FIND,        7'd0,   32'd0,          1'b1, ST_EMPTY, 32'd0,          7'd0),
      mk_row(OP_TEST_FST,    7'd0,   32'd0,          1'b1, ST_EMPTY, 32'd0,          7'd0),
      mk_row(OP_TEST_LST,    7'd0,   32'd0,          1'b1, ST_EMPTY, 32'd0,          7'd0),
      mk_row(OP_INS_POS,     7'd1,   32'd7,          1'b1, ST_RANGE, 32'd0,          7'd0),
      mk_row(OP_INS_POS,     7'd0,   32'h7fff_ffff,  1'b1, ST_OK,    32'd0,          7'd1),
      mk_row(OP_INS_FRONT,   7'd127, 32'h8000_0000,  1'b1, ST_OK,    32'd0,          7'd2),
      mk_row(OP_INS_REAR,    7'd0,   32'd0,          1'b1, ST_OK,    32'd0,          7'd3),
      mk_row(OP_INS_POS,     7'd127, 32'hffff_ffff,  1'b1, ST_RANGE, 32'd0,          7'd3),
      mk_row(OP_READ,        7'd0,   32'd0,          1'b1, ST_OK,    32'h8000_0000,  7'd3),
      mk_row(OP_READ,        7'd127, 32'd0,          1'b1, ST_RANGE, 32'd0,          7'd3),
      mk_row(OP_FIND,        7'd0,   32'h7fff_ffff,  1'b0, ST_OK,    32'd0,          7'd0),
      mk_row(OP_FIND,        7'd0,   32'd12345,      1'b1, ST_NOTFOUND, 32'd0,       7'd3),
      mk_row(OP_TEST_FST,    7'd0,   32'h8000_0000,  1'b0, ST_OK,    32'd0,          7'd0),
      mk_row(OP_TEST_LST,    7'd0,   32'd5,          1'b0, ST_OK,    32'd0,          7'd0),
      mk_row(OP_READ_DEL,    7'd1,   32'd0,          1'b1, ST_OK,    32'h7fff_ffff,  7'd2),
      mk_row(OP_DEL_POS,     7'd2,   32'd0,          1'b1, ST_RANGE, 32'd0,          7'd2),
      mk_row(OP_DEL_POS,     7'd1,   32'd0,          1'b0, ST_OK,    32'd0,          7'd0),
      mk_row(OP_SPARE_FIRST, 7'd127, 32'hffff_ffff,  1'b1, ST_OK,    32'd0,          7'd1),
      mk_row(OP_SPARE_LAST,  7'd0,   32'd0,          1'b1, ST_OK,    32'd0,          7'd1),
      mk_row(OP_DEL_LAST,    7'd0,   32'd0,          1'b1, ST_OK,    32'h8000_0000,  7'd0),
      mk_row(OP_INS_REAR,    7'd0,   32'hffff_ffff,  1'b0, ST_OK,    32'd0,          7'd0),
      mk_row(OP_CLEAR,       7'd0,   32'd0,          1'b1, ST_OK,    32'd0,          7'd0)
    };

    // Hold reset, release on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                directed_rows[i].typed, directed_rows[i].exp);

    // Three random phases: light request idling, heavy idling, none at all.
    // Each opens by filling the list so the full cases come up every time.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 73 : 0;
      fill_list();
      counted = 0;
      while (counted < ITEMS_PER_PHASE) send_random_word(counted);
    end

    // Drop start, drain outstanding words, then watch for strays
    start = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("ordered_list_engine_core test passed");
    end else begin
      $display("ordered_list_engine_core test failed");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal schedule
  initial begin
    #(20_000_000);
    $display("ordered_list_engine_core test failed");
    $finish;
  end

endmodule
